// File: rtl/core/command_line_recognizer_top_macros.svh
// Assertion helpers for the checker of this block
`ifndef COMMAND_LINE_RECOGNIZER_TOP_MACROS_SVH
`define COMMAND_LINE_RECOGNIZER_TOP_MACROS_SVH

// Checked only out of reset
`define CLR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("clr check failed");

// Checked during reset as well
`define CLR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("clr reset check failed");

`endif

// File: rtl/core/clr_pkg.sv
`default_nettype none

package clr_pkg;

    localparam int NAME_BUFFER  = 32;
    localparam int NUM_COMMANDS = 8;
    localparam int TABLE_SIZE   = 8;
    localparam int ROM_CHARS    = 20;
    localparam int POS_W        = $clog2(NAME_BUFFER);
    localparam int IDX_W        = $clog2(TABLE_SIZE);
    localparam int ROM_POS_W    = 5;
    localparam int LEN_W        = 5;

    localparam logic [1:0] KIND_CMD = 2'd0;
    localparam logic [1:0] KIND_MM  = 2'd1;
    localparam logic [1:0] KIND_IGN = 2'd2;

    localparam logic [9:0] MM_PER_M  = 10'd1000;
    localparam logic [1:0] FRAC_KEEP = 2'd3;

    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
    } t_in;

    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] cmd_index;
        logic [31:0]      mm_value;
        logic             wrapped;
    } t_out;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_name_res;

    typedef struct packed {
        logic        ok;
        logic [31:0] mm;
        logic        wrapped;
    } t_num_res;

    function automatic logic [LEN_W-1:0] cmd_len(input logic [IDX_W-1:0] i);
        logic [LEN_W-1:0] n;
        case (i)
            3'd0:    n = 5'd15;
            3'd1:    n = 5'd7;
            3'd2:    n = 5'd7;
            3'd3:    n = 5'd18;
            3'd4:    n = 5'd12;
            3'd5:    n = 5'd12;
            3'd6:    n = 5'd12;
            3'd7:    n = 5'd7;
            default: n = 5'd0;
        endcase
        return n;
    endfunction

    // Character p of command i, zero past the end of the name
    function automatic logic [7:0] cmd_char(input logic [IDX_W-1:0] i,
                                            input logic [ROM_POS_W-1:0] p);
        logic [8*ROM_CHARS-1:0] s;
        logic [LEN_W-1:0]       n;
        int                     off;
        case (i)
            3'd0:    s = {"AT+GET_ALL", "_INFO"};
            3'd1:    s = "AT+SAVE";
            3'd2:    s = "AT+BATT";
            3'd3:    s = {"AT+CLEAR_ALL", "_FLASH"};
            3'd4:    s = {"AT+KEY", "_SHORT"};
            3'd5:    s = {"AT+KEY", "_LONG3"};
            3'd6:    s = {"AT+KEY", "_LONG5"};
            3'd7:    s = "AT+HELP";
            default: s = '0;
        endcase
        n = cmd_len(i);
        off = 8 * (int'(n) - 1 - int'(p));
        if (p < n) begin
            return s[off +: 8];
        end
        return 8'd0;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/clr_name_match.sv
`default_nettype none

module clr_name_match (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire logic               i_clear,
    input  wire logic [7:0]         i_ch,
    output clr_pkg::t_name_res      o_res
);
    import clr_pkg::*;

    localparam logic [1:0] PH_LEAD = 2'd0;
    localparam logic [1:0] PH_WORD = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    logic [1:0]              r_phase, n_phase;
    logic [POS_W-1:0]        r_pos, n_pos;
    logic [NUM_COMMANDS-1:0] r_alive, n_alive;

    logic       blank;
    logic       take;
    logic [7:0] upc;

    assign blank = (i_ch == 8'h20) || (i_ch == 8'h09);
    assign upc   = ((i_ch >= 8'h61) && (i_ch <= 8'h7a)) ? (i_ch - 8'h20) : i_ch;
    assign take  = !blank && ((r_phase == PH_LEAD) || (r_phase == PH_WORD));

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_alive = r_alive;
        if (i_step) begin
            case (r_phase)
                PH_LEAD: begin
                    if (!blank) begin
                        n_phase = PH_WORD;
                    end
                end
                PH_WORD: begin
                    if (blank) begin
                        n_phase = PH_DONE;
                    end
                end
                default: n_phase = r_phase;
            endcase
            // only the first NAME_BUFFER-1 characters of the word are compared
            if (take && (r_pos < POS_W'(NAME_BUFFER - 1))) begin
                for (int i = 0; i < NUM_COMMANDS; i++) begin
                    if ((r_pos >= POS_W'(cmd_len(IDX_W'(i)))) ||
                        (upc != cmd_char(IDX_W'(i), r_pos[ROM_POS_W-1:0]))) begin
                        n_alive[i] = 1'b0;
                    end
                end
                n_pos = r_pos + 1'b1;
            end
        end
        if (i_clear) begin
            n_phase = PH_LEAD;
            n_pos   = '0;
            n_alive = '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_pos   <= '0;
            r_alive <= '1;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_alive <= n_alive;
        end
    end

    // lowest matching index wins
    always_comb begin
        o_res = '0;
        for (int i = NUM_COMMANDS - 1; i >= 0; i--) begin
            if (r_alive[i] && (r_pos == POS_W'(cmd_len(IDX_W'(i))))) begin
                o_res.hit = (r_phase != PH_LEAD);
                o_res.idx = IDX_W'(i);
            end
        end
        if (!o_res.hit) begin
            o_res.idx = '0;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/clr_num_parse.sv
`default_nettype none

module clr_num_parse (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_step,
    input  wire logic         i_clear,
    input  wire logic [7:0]   i_ch,
    output clr_pkg::t_num_res o_res
);
    import clr_pkg::*;

    logic [31:0] r_int, n_int;
    logic [9:0]  r_frac, n_frac;
    logic [1:0]  r_fcnt, n_fcnt;
    logic        r_digit, n_digit;
    logic        r_infrac, n_infrac;
    logic        r_bad, n_bad;
    logic        r_wrap, n_wrap;

    logic        is_digit;
    logic        is_point;
    logic [3:0]  dval;
    logic [35:0] int_x10;
    logic [13:0] frac_x10;
    logic [9:0]  frac_scaled;
    logic [41:0] mm_full;

    assign is_digit = (i_ch >= 8'h30) && (i_ch <= 8'h39);
    assign is_point = (i_ch == 8'h2e);
    assign dval     = i_ch[3:0];
    assign int_x10  = {1'b0, r_int, 3'b000} + {3'b000, r_int, 1'b0} + {32'd0, dval};
    assign frac_x10 = {1'b0, r_frac, 3'b000} + {3'b000, r_frac, 1'b0} + {10'd0, dval};

    always_comb begin
        n_int    = r_int;
        n_frac   = r_frac;
        n_fcnt   = r_fcnt;
        n_digit  = r_digit;
        n_infrac = r_infrac;
        n_bad    = r_bad;
        n_wrap   = r_wrap;
        if (i_step && !r_bad) begin
            if (is_point) begin
                n_bad    = r_infrac;
                n_infrac = 1'b1;
            end else if (is_digit) begin
                n_digit = 1'b1;
                if (r_infrac) begin
                    if (r_fcnt < FRAC_KEEP) begin
                        n_frac = frac_x10[9:0];
                        n_fcnt = r_fcnt + 1'b1;
                    end
                end else begin
                    n_int = int_x10[31:0];
                    if (int_x10[35:32] != 4'd0) begin
                        n_wrap = 1'b1;
                    end
                end
            end else begin
                n_bad = 1'b1;
            end
        end
        if (i_clear) begin
            n_int    = '0;
            n_frac   = '0;
            n_fcnt   = '0;
            n_digit  = 1'b0;
            n_infrac = 1'b0;
            n_bad    = 1'b0;
            n_wrap   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int    <= '0;
            r_frac   <= '0;
            r_fcnt   <= '0;
            r_digit  <= 1'b0;
            r_infrac <= 1'b0;
            r_bad    <= 1'b0;
            r_wrap   <= 1'b0;
        end else begin
            r_int    <= n_int;
            r_frac   <= n_frac;
            r_fcnt   <= n_fcnt;
            r_digit  <= n_digit;
            r_infrac <= n_infrac;
            r_bad    <= n_bad;
            r_wrap   <= n_wrap;
        end
    end

    // pad the kept fraction digits out to three
    always_comb begin
        case (r_fcnt)
            2'd1:    frac_scaled = 10'(r_frac * 10'd100);
            2'd2:    frac_scaled = 10'(r_frac * 10'd10);
            2'd3:    frac_scaled = r_frac;
            default: frac_scaled = 10'd0;
        endcase
    end

    assign mm_full = (r_int * MM_PER_M) + {32'd0, frac_scaled};

    assign o_res.ok      = r_digit && !r_bad;
    assign o_res.mm      = mm_full[31:0];
    assign o_res.wrapped = r_wrap || (mm_full[41:32] != 10'd0);

endmodule

`default_nettype wire

// File: rtl/core/command_line_recognizer_top.sv
// Latency: the result is valid in the cycle after the end-of-line beat is taken.
// Throughput: one character beat per cycle; character beats are taken even while
// a result waits, only an end-of-line beat waits for the result register to free.
// Reset (i_rst_n low, synchronous): line state back to its start, result dropped.
`default_nettype none

module command_line_recognizer_top (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire clr_pkg::t_in i_in_data,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output clr_pkg::t_out o_out_data
);
    import clr_pkg::*;

    logic      is_end;
    logic      accept;
    logic      step;
    logic      clear;
    t_name_res name_res;
    t_num_res  num_res;

    logic      r_out_valid, n_out_valid;
    t_out      r_out_data, n_out_data;

    assign is_end     = i_in_data.line_end || (i_in_data.ch == 8'd0);
    assign o_in_ready = !is_end || !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign step       = accept && !is_end;
    assign clear      = accept && is_end;

    clr_name_match u_name (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_clear (clear),
        .i_ch    (i_in_data.ch),
        .o_res   (name_res)
    );

    clr_num_parse u_num (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_clear (clear),
        .i_ch    (i_in_data.ch),
        .o_res   (num_res)
    );

    always_comb begin
        n_out_data      = '0;
        n_out_data.kind = KIND_IGN;
        if (name_res.hit) begin
            n_out_data.kind      = KIND_CMD;
            n_out_data.cmd_index = name_res.idx;
        end else if (num_res.ok) begin
            n_out_data.kind     = KIND_MM;
            n_out_data.mm_value = num_res.mm;
            n_out_data.wrapped  = num_res.wrapped;
        end
    end

    assign n_out_valid = clear || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (clear) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// File: rtl/core/clr_checker.sv
`default_nettype none

`include "command_line_recognizer_top_macros.svh"

module clr_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_ready,
    input wire clr_pkg::t_in   i_in_data,
    input wire logic           o_out_valid,
    input wire logic           i_out_ready,
    input wire clr_pkg::t_out  o_out_data
);
    import clr_pkg::*;

    logic end_beat;

    assign end_beat = i_in_valid && o_in_ready &&
                      (i_in_data.line_end || (i_in_data.ch == 8'd0));

    // a stalled result beat holds
    `CLR_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))

    // a new result only follows an accepted end of line
    `CLR_ASSERT(a_out_cause, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(end_beat))

    // cmd_index is zero outside CMD, mm_value and wrapped are zero for IGN, and kind is a known code
    `CLR_ASSERT(a_out_fields, i_clk, i_rst_n,
        o_out_valid |-> (o_out_data.kind == KIND_CMD ||
                         (o_out_data.cmd_index == '0 &&
                          (o_out_data.kind == KIND_MM ||
                           (o_out_data.kind == KIND_IGN &&
                            o_out_data.mm_value == 32'd0 && !o_out_data.wrapped)))))

    // reset drops any pending result
    `CLR_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind command_line_recognizer_top clr_checker u_clr_checker (.*);

`default_nettype wire

// File: test/command_line_recognizer_top_tb.sv
`timescale 1ns / 100ps

module command_line_recognizer_top_tb;
    import clr_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BEATS    = 380;
    localparam int TAIL_CYCLES    = 8;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_WORD,
        PH_AFTER
    } t_word_phase;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    command_line_recognizer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    string cmd_names [TABLE_SIZE];

    // line state of the predictor
    t_word_phase word_phase;
    logic [5:0]  word_len;
    logic [7:0]  alive;
    logic [31:0] metres;
    logic [9:0]  frac_kept;
    logic [1:0]  frac_n;
    bit          seen_digit;
    bit          after_point;
    bit          not_number;
    bit          metres_wrapped;

    t_out        expected_results [$];
    logic [7:0]  line_buf [$];
    int          mismatch_count = 0;
    int          n_in_beats = 0;
    int          quiet_cycles = 0;
    int unsigned send_idle_pct = 10;
    int unsigned recv_idle_pct = 57;

    function automatic string rom_name(input int idx);
        string s;
        s = "";
        for (int p = 0; p < int'(cmd_len(IDX_W'(idx))); p++) begin
            s = $sformatf("%s%c", s, cmd_char(IDX_W'(idx), ROM_POS_W'(p)));
        end
        return s;
    endfunction

    function automatic void load_names();
        for (int i = 0; i < TABLE_SIZE; i++) begin
            cmd_names[i] = rom_name(i);
        end
    endfunction

    function automatic void clear_line_state();
        word_phase     = PH_LEAD;
        word_len       = '0;
        alive          = 8'((9'd1 << NUM_COMMANDS) - 9'd1);
        metres         = '0;
        frac_kept      = '0;
        frac_n         = '0;
        seen_digit     = 1'b0;
        after_point    = 1'b0;
        not_number     = 1'b0;
        metres_wrapped = 1'b0;
    endfunction

    function automatic void compare_name_char(input logic [7:0] c);
        logic [7:0] u;
        string      nm;
        u = c;
        if (c >= "a" && c <= "z") begin
            u = c - 8'd32;
        end
        if (word_len >= NAME_BUFFER - 1) begin
            return;
        end
        for (int i = 0; i < NUM_COMMANDS; i++) begin
            nm = cmd_names[i];
            if (word_len >= nm.len() || u != nm[word_len]) begin
                alive[i] = 1'b0;
            end
        end
        word_len++;
    endfunction

    // Returns 1 when the beat closes a line; res then holds the line's result
    function automatic bit recognize_beat(input t_in beat, output t_out res);
        logic [7:0]  c;
        logic [63:0] wide;
        logic [31:0] f;
        int          n;
        bit          blank;
        string       nm;
        c   = beat.ch;
        res = '0;
        if (!beat.line_end && c != 8'd0) begin
            blank = (c == " " || c == "\t");
            case (word_phase)
                PH_LEAD: begin
                    if (!blank) begin
                        word_phase = PH_WORD;
                        compare_name_char(c);
                    end
                end
                PH_WORD: begin
                    if (blank) begin
                        word_phase = PH_AFTER;
                    end else begin
                        compare_name_char(c);
                    end
                end
                default: ;
            endcase
            if (!not_number) begin
                if (c == ".") begin
                    if (after_point) begin
                        not_number = 1'b1;
                    end
                    after_point = 1'b1;
                end else if (c >= "0" && c <= "9") begin
                    seen_digit = 1'b1;
                    if (after_point) begin
                        if (frac_n < FRAC_KEEP) begin
                            frac_kept = 10'(frac_kept * 10 + (c - "0"));
                            frac_n++;
                        end
                    end else begin
                        wide = 64'(metres) * 64'd10 + 64'(c - "0");
                        if (wide[63:32] != '0) begin
                            metres_wrapped = 1'b1;
                        end
                        metres = wide[31:0];
                    end
                end else begin
                    not_number = 1'b1;
                end
            end
            return 1'b0;
        end
        res.kind = KIND_IGN;
        if (word_phase != PH_LEAD) begin
            for (int i = 0; i < NUM_COMMANDS; i++) begin
                nm = cmd_names[i];
                if (alive[i] && word_len == nm.len()) begin
                    res.kind      = KIND_CMD;
                    res.cmd_index = IDX_W'(i);
                    clear_line_state();
                    return 1'b1;
                end
            end
        end
        if (!not_number && seen_digit) begin
            f = 32'(frac_kept);
            n = frac_n;
            while (n < FRAC_KEEP) begin
                f = f * 10;
                n++;
            end
            wide         = 64'(metres) * 64'(MM_PER_M) + 64'(f);
            res.kind     = KIND_MM;
            res.mm_value = wide[31:0];
            res.wrapped  = metres_wrapped || wide[63:32] != '0;
        end
        clear_line_state();
        return 1'b1;
    endfunction

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker, expectation builder and watchdog
    always @(posedge i_clk) begin
        t_out got;
        t_out want;
        t_out fresh;
        bit   took;
        if (i_rst_n) begin
            took = 1'b0;
            if (o_out_valid && i_out_ready) begin
                took = 1'b1;
                got  = o_out_data;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result kind %0d idx %0d mm %0d wrap %0b",
                             $time, got.kind, got.cmd_index, got.mm_value, got.wrapped);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind || got.cmd_index !== want.cmd_index ||
                        got.mm_value !== want.mm_value || got.wrapped !== want.wrapped)
                    begin
                        $display("%0t: expected kind %0d idx %0d mm %0d wrap %0b",
                                 $time, want.kind, want.cmd_index, want.mm_value,
                                 want.wrapped);
                        $display("%0t:   actual kind %0d idx %0d mm %0d wrap %0b",
                                 $time, got.kind, got.cmd_index, got.mm_value,
                                 got.wrapped);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                took = 1'b1;
                n_in_beats++;
                if (recognize_beat(i_in_data, fresh)) begin
                    expected_results.push_back(fresh);
                end
            end
            quiet_cycles = took ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is
    // taken with valid still high, so the caller either sends again or drops
    // valid in that same step.
    task automatic send_beat(input t_in beat);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        forever begin
            @(posedge i_clk);
            if (o_in_ready) begin
                break;
            end
        end
        @(negedge i_clk);
    endtask

    task automatic send_line(input bit zero_end);
        t_in beat;
        foreach (line_buf[i]) begin
            beat.ch       = line_buf[i];
            beat.line_end = 1'b0;
            send_beat(beat);
        end
        if (zero_end) begin
            beat.ch       = 8'h00;
            beat.line_end = 1'b0;
        end else begin
            beat.ch       = 8'($urandom_range(255));
            beat.line_end = 1'b1;
        end
        send_beat(beat);
    endtask

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            line_buf.push_back(s[i]);
        end
    endfunction

    task automatic run_text(input string s, input bit zero_end);
        line_buf.delete();
        add_text(s);
        send_line(zero_end);
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic test_command_names();
        string s;
        string lc;
        run_text(cmd_names[0], 1'b0);
        run_text(cmd_names[1].tolower(), 1'b0);
        run_text("At+BaTt", 1'b0);
        run_text({" \t", cmd_names[3]}, 1'b0);
        run_text({cmd_names[4], " arg"}, 1'b0);
        run_text(cmd_names[5], 1'b0);
        // upper-case prefix, lower-case tail, then arguments after a tab
        lc = cmd_names[6].tolower();
        s  = {cmd_names[6].substr(0, 2), lc.substr(3, lc.len() - 1), "\tx y"};
        run_text(s, 1'b0);
        run_text(cmd_names[7], 1'b0);
    endtask

    task automatic test_metre_values();
        run_text("0", 1'b0);
        run_text("12.3456", 1'b0);
        run_text(".5", 1'b0);
        run_text("7.", 1'b0);
        run_text("4294967.295", 1'b0);
        run_text("4294967.296", 1'b0);
        run_text("99999999999", 1'b0);
        run_text("1.2.3", 1'b0);
        run_text(" 12", 1'b0);
    endtask

    task automatic test_line_edges();
        run_text("", 1'b0);
        run_text("   \t", 1'b0);
        run_text(".", 1'b0);
        run_text("AT+SAV", 1'b0);
        run_text("AT+SAVEX", 1'b0);
        run_text({cmd_names[3], "ABCDEFGHIJKLMNOPQRSTU"}, 1'b0);
        run_text("AT+HELP", 1'b1);
        line_buf.delete();
        add_text("AT+");
        line_buf.push_back(8'hC8);
        add_text("ELP");
        send_line(1'b0);
        line_buf.delete();
        add_text("12");
        line_buf.push_back(8'hB0);
        line_buf.push_back(8'hFF);
        send_line(1'b1);
    endtask

    function automatic void build_random_line();
        int         pick;
        int         start;
        string      nm;
        logic [7:0] c;
        line_buf.delete();
        pick = $urandom_range(99);
        if (pick < 40) begin
            // command name, random case, sometimes damaged
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    line_buf.push_back($urandom_range(1) ? 8'h20 : 8'h09);
                end
            end
            nm    = cmd_names[$urandom_range(TABLE_SIZE - 1)];
            start = line_buf.size();
            for (int j = 0; j < nm.len(); j++) begin
                c = nm[j];
                if (c >= "A" && c <= "Z" && $urandom_range(1)) begin
                    c = c + 8'd32;
                end
                line_buf.push_back(c);
            end
            case ($urandom_range(7))
                0: void'(line_buf.pop_back());
                1: line_buf[start + $urandom_range(nm.len() - 1)] = 8'($urandom_range(1, 255));
                2: line_buf.push_back(8'($urandom_range(33, 126)));
                default: ;
            endcase
            if ($urandom_range(2) == 0) begin
                line_buf.push_back($urandom_range(1) ? 8'h20 : 8'h09);
                repeat ($urandom_range(10)) begin
                    line_buf.push_back(8'($urandom_range(32, 126)));
                end
            end
        end else if (pick < 70) begin
            // metre value: integer part, optional point and fraction
            repeat (($urandom_range(9) == 0) ? $urandom_range(10, 14) : $urandom_range(7)) begin
                line_buf.push_back(8'("0" + $urandom_range(9)));
            end
            if ($urandom_range(2) != 0) begin
                line_buf.push_back(".");
                repeat ($urandom_range(6)) begin
                    line_buf.push_back(8'("0" + $urandom_range(9)));
                end
            end
            if ($urandom_range(9) == 0) begin
                line_buf.insert($urandom_range(line_buf.size()),
                                $urandom_range(1) ? 8'h2E : 8'($urandom_range(33, 126)));
            end
            if ($urandom_range(9) == 0) begin
                line_buf.push_front(8'h20);
            end
        end else if (pick < 90) begin
            repeat ($urandom_range(40)) begin
                line_buf.push_back(8'($urandom_range(255)));
            end
        end else begin
            // long word that may run past the compare window
            if ($urandom_range(1)) begin
                add_text(cmd_names[$urandom_range(TABLE_SIZE - 1)]);
            end
            repeat ($urandom_range(20, 40)) begin
                line_buf.push_back(8'($urandom_range(33, 126)));
            end
        end
    endfunction

    task automatic test_random_lines();
        int target;
        for (int phase = 0; phase < 3; phase++) begin
            wait_results_drained();
            case (phase)
                0: begin
                    send_idle_pct = 10;
                    recv_idle_pct = 57;
                end
                1: begin
                    send_idle_pct = 57;
                    recv_idle_pct = 10;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            target = n_in_beats + PHASE_BEATS;
            while (n_in_beats < target) begin
                build_random_line();
                send_line($urandom_range(4) == 0);
            end
        end
    endtask

    initial begin
        load_names();
        clear_line_state();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_command_names();
        test_metre_values();
        test_line_edges();
        test_random_lines();
        wait_results_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
